// File: sv/cir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cir_pkg;

  typedef logic signed [31:0] fx_t;

  // y in the high word, x in the low word, as on the ports
  typedef struct packed {
    fx_t y;
    fx_t x;
  } vec_t;

  typedef struct packed {
    logic [63:0]        a_position;
    logic [63:0]        a_velocity;
    logic [30:0]        a_inv_mass;
    logic [31:0]        a_material;
    logic               a_static;
    logic [63:0]        b_position;
    logic [63:0]        b_velocity;
    logic [30:0]        b_inv_mass;
    logic [31:0]        b_material;
    logic               b_static;
    logic [63:0]        contact_normal;
    logic signed [31:0] penetration;
  } in_t;

  typedef struct packed {
    logic [63:0] new_a_position;
    logic [63:0] new_a_velocity;
    logic [63:0] new_b_position;
    logic [63:0] new_b_velocity;
  } out_t;

  // per-contact context carried down the pipeline
  typedef struct packed {
    vec_t               pa;
    vec_t               va;
    vec_t               pb;
    vec_t               vb;
    vec_t               n;
    vec_t               cv;
    vec_t               da;
    vec_t               db;
    vec_t               rv;
    vec_t               iv;
    vec_t               t;
    vec_t               u;
    logic [30:0]        ima;
    logic [30:0]        imb;
    logic [31:0]        total;
    logic               sa;
    logic               sb;
    logic               act;
    logic               pen_pos;
    logic               imp;
    logic               fric;
    fx_t                pen;
    fx_t                vn;
    fx_t                j;
    fx_t                dtu;
    fx_t                jt;
    fx_t                lim;
    logic [15:0]        ea;
    logic [15:0]        eb;
    logic [15:0]        fa;
    logic [15:0]        fb;
    logic [15:0]        mu;
    logic [16:0]        ope;
    logic [31:0]        mu_sq;
    logic [31:0]        len;
    logic signed [63:0] tdx;
    logic signed [63:0] tdy;
    logic [63:0]        tsq_x;
    logic [63:0]        tsq_y;
    logic [63:0]        tsq;
  } ctx_t;

  // quotient bits below the saturation point
  localparam int DIV_QB = 31;
  // restitution and friction scales are Q0.16
  localparam int EQ_FRAC = 16;
  localparam logic [16:0] E_ONE = 17'h10000;

  localparam fx_t FX_MAX = 32'sh7fffffff;
  localparam fx_t FX_MIN = 32'sh80000000;
  localparam logic signed [63:0] S64_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S64_MIN = -64'sd2147483648;

  function automatic fx_t sat_fx(input logic signed [63:0] v);
    if (v > S64_MAX) begin
      return FX_MAX;
    end else if (v < S64_MIN) begin
      return FX_MIN;
    end
    return v[31:0];
  endfunction

  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    return sat_fx(64'(a) + 64'(b));
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    return sat_fx(64'(a) - 64'(b));
  endfunction

  // product shifted down, floor rounding
  function automatic logic signed [63:0] fx_term(input fx_t a, input fx_t b,
                                                 input int unsigned sh);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> sh;
  endfunction

  function automatic fx_t fx_mul(input fx_t a, input fx_t b, input int unsigned sh);
    return sat_fx(fx_term(a, b, sh));
  endfunction

  function automatic vec_t vec_mul(input vec_t v, input fx_t s, input int unsigned sh);
    vec_t r;
    r.x = fx_mul(v.x, s, sh);
    r.y = fx_mul(v.y, s, sh);
    return r;
  endfunction

  function automatic vec_t vec_add(input vec_t a, input vec_t b);
    vec_t r;
    r.x = fx_add(a.x, b.x);
    r.y = fx_add(a.y, b.y);
    return r;
  endfunction

  function automatic vec_t vec_sub(input vec_t a, input vec_t b);
    vec_t r;
    r.x = fx_sub(a.x, b.x);
    r.y = fx_sub(a.y, b.y);
    return r;
  endfunction

  function automatic logic [31:0] fx_mag(input fx_t a);
    logic signed [32:0] w;
    w = 33'(a);
    if (a < 0) begin
      w = -w;
    end
    return w[31:0];
  endfunction

  function automatic fx_t im_fx(input logic [30:0] m);
    return fx_t'({1'b0, m});
  endfunction

endpackage

`default_nettype wire

// File: sv/cir_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, result
// truncated toward zero and saturated to the signed 32-bit range.
// Computes sign * floor(mag * 2^FRAC_BITS / den) for each lane.
module cir_div #(
  parameter int FRAC_BITS = 16,
  parameter int LANES     = 1,
  parameter int SIDE_W    = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_v,
  input  wire logic [LANES-1:0]    in_neg,
  input  wire logic [31:0]         in_mag [LANES],
  input  wire logic [31:0]         in_den,
  input  wire logic [SIDE_W-1:0]   in_side,
  output logic                     out_v,
  output cir_pkg::fx_t             out_q [LANES],
  output logic [SIDE_W-1:0]        out_side
);

  localparam int QB = cir_pkg::DIV_QB;
  localparam int NW = 32 + FRAC_BITS;

  logic              v_r    [QB+1];
  logic [SIDE_W-1:0] side_r [QB+1];
  logic [31:0]       den_r  [QB+1];
  logic [LANES-1:0]  neg_r  [QB+1];
  logic [LANES-1:0]  ovf_r  [QB+1];
  logic [32:0]       rem_r  [QB+1][LANES];
  logic [QB-1:0]     lo_r   [QB+1][LANES];
  logic [QB-1:0]     q_r    [QB+1][LANES];

  logic [LANES-1:0] ovf_nxt;
  logic [32:0]      rem0_nxt [LANES];
  logic [QB-1:0]    lo0_nxt  [LANES];

  // entry: overflow test and first partial remainder
  always_comb begin
    logic [NW-1:0] num;
    for (int l = 0; l < LANES; l++) begin
      num         = {in_mag[l], {FRAC_BITS{1'b0}}};
      ovf_nxt[l]  = 33'(num[NW-1:QB]) >= 33'(in_den);
      rem0_nxt[l] = 33'(num[NW-1:QB]);
      lo0_nxt[l]  = num[QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    den_r[0]  <= in_den;
    neg_r[0]  <= in_neg;
    ovf_r[0]  <= ovf_nxt;
    for (int l = 0; l < LANES; l++) begin
      rem_r[0][l] <= rem0_nxt[l];
      lo_r[0][l]  <= lo0_nxt[l];
      q_r[0][l]   <= '0;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stg
    logic [32:0]   rem_nxt [LANES];
    logic [QB-1:0] lo_nxt  [LANES];
    logic [QB-1:0] q_nxt   [LANES];

    always_comb begin
      logic [32:0] t;
      logic        ge;
      for (int l = 0; l < LANES; l++) begin
        t          = {rem_r[k-1][l][31:0], lo_r[k-1][l][QB-1]};
        ge         = t >= {1'b0, den_r[k-1]};
        rem_nxt[l] = ge ? (t - {1'b0, den_r[k-1]}) : t;
        lo_nxt[l]  = lo_r[k-1][l] << 1;
        q_nxt[l]   = {q_r[k-1][l][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_r[k-1];
      den_r[k]  <= den_r[k-1];
      neg_r[k]  <= neg_r[k-1];
      ovf_r[k]  <= ovf_r[k-1];
      for (int l = 0; l < LANES; l++) begin
        rem_r[k][l] <= rem_nxt[l];
        lo_r[k][l]  <= lo_nxt[l];
        q_r[k][l]   <= q_nxt[l];
      end
    end
  end

  always_comb begin
    cir_pkg::fx_t qs;
    for (int l = 0; l < LANES; l++) begin
      qs = cir_pkg::fx_t'({1'b0, q_r[QB][l]});
      if (ovf_r[QB][l]) begin
        out_q[l] = neg_r[QB][l] ? cir_pkg::FX_MIN : cir_pkg::FX_MAX;
      end else begin
        out_q[l] = neg_r[QB][l] ? -qs : qs;
      end
    end
  end

  assign out_v    = v_r[QB];
  assign out_side = side_r[QB];

endmodule

`default_nettype wire

// File: sv/cir_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined floor square root, one root bit per stage.
module cir_sqrt #(
  parameter int W      = 64,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_v,
  input  wire logic [W-1:0]      in_val,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_v,
  output logic [W/2-1:0]         out_root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int H = W / 2;

  logic              v_r    [H+1];
  logic [SIDE_W-1:0] side_r [H+1];
  logic [H+1:0]      rem_r  [H+1];
  logic [H-1:0]      root_r [H+1];
  logic [W-1:0]      val_r  [H+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    val_r[0]  <= in_val;
  end

  for (genvar k = 1; k <= H; k++) begin : g_stg
    logic [H+1:0] rem_nxt;
    logic [H-1:0] root_nxt;
    logic [W-1:0] val_nxt;

    always_comb begin
      logic [H+2:0] t;
      logic [H+2:0] trial;
      logic         ge;
      // bring down the next two radicand bits
      t        = {rem_r[k-1][H:0], val_r[k-1][W-1:W-2]};
      trial    = {1'b0, root_r[k-1], 2'b01};
      ge       = t >= trial;
      rem_nxt  = ge ? (H+2)'(t - trial) : t[H+1:0];
      root_nxt = {root_r[k-1][H-2:0], ge};
      val_nxt  = val_r[k-1] << 2;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_r[k-1];
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      val_r[k]  <= val_nxt;
    end
  end

  assign out_v    = v_r[H];
  assign out_root = root_r[H];
  assign out_side = side_r[H];

endmodule

`default_nettype wire

// File: sv/contact_impulse_resolver_2d.sv
`timescale 1ns / 1ps
`default_nettype none

// 2D contact resolver: one contact in, corrected positions and velocities out.
// Input: drive in_data and raise start; the contact transfers at a rising edge
// with start high and busy low. busy is high from reset until the first edge
// after rst_n rises; from then on a new contact can transfer on every cycle.
// Output: out_strobe is high for one cycle with out_data; the receiver takes it
// at the edge that ends that cycle and cannot hold it off. Results leave in
// transfer order.
// Structure: four bit-per-stage dividers (32 stages each), two root
// extractors (17 and 33 stages) and 27 multiply/add stages make up the
// pipeline.
// Throughput: one contact per cycle.
// Reset: synchronous, active low; it clears every valid bit, so nothing in
// flight comes out after reset. All arithmetic is signed fixed point with
// FRAC_BITS fraction bits and saturates to 32 bits per component.
module contact_impulse_resolver_2d #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire cir_pkg::in_t   in_data,
  output logic                out_strobe,
  output cir_pkg::out_t       out_data
);

  localparam int NSTG  = 27;
  localparam int CTX_W = $bits(cir_pkg::ctx_t);

  logic busy_r;

  cir_pkg::ctx_t s_r   [NSTG];
  cir_pkg::ctx_t s_nxt [NSTG];
  logic          v_r   [NSTG];
  logic          v_nxt [NSTG];

  // unit outputs
  logic          mu_v, c_v, jq_v, len_v, u_v, f_v;
  cir_pkg::ctx_t mu_ctx, c_ctx, jq_ctx, len_ctx, u_ctx, f_ctx;
  logic [15:0]   mu_root;
  logic [31:0]   len_root;
  cir_pkg::fx_t  c_q  [1];
  cir_pkg::fx_t  jq_q [1];
  cir_pkg::fx_t  u_q  [2];
  cir_pkg::fx_t  f_q  [2];

  // unit inputs
  logic [31:0] c_mag  [1];
  logic [31:0] jq_mag [1];
  logic [31:0] u_mag  [2];
  logic [31:0] f_mag  [2];
  logic [1:0]  u_neg;
  logic [1:0]  f_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  always_comb begin
    // capture
    s_nxt[0]         = '0;
    s_nxt[0].pa      = in_data.a_position;
    s_nxt[0].va      = in_data.a_velocity;
    s_nxt[0].pb      = in_data.b_position;
    s_nxt[0].vb      = in_data.b_velocity;
    s_nxt[0].n       = in_data.contact_normal;
    s_nxt[0].ima     = in_data.a_inv_mass;
    s_nxt[0].imb     = in_data.b_inv_mass;
    s_nxt[0].sa      = in_data.a_static;
    s_nxt[0].sb      = in_data.b_static;
    s_nxt[0].pen     = in_data.penetration;
    s_nxt[0].ea      = in_data.a_material[15:0];
    s_nxt[0].fa      = in_data.a_material[31:16];
    s_nxt[0].eb      = in_data.b_material[15:0];
    s_nxt[0].fb      = in_data.b_material[31:16];

    // total inverse mass, friction product, restitution scale
    s_nxt[1]         = s_r[0];
    s_nxt[1].total   = 32'(s_r[0].ima) + 32'(s_r[0].imb);
    s_nxt[1].act     = (s_r[0].ima != '0) || (s_r[0].imb != '0);
    s_nxt[1].pen_pos = s_r[0].pen > 0;
    s_nxt[1].mu_sq   = 32'(s_r[0].fa) * 32'(s_r[0].fb);
    s_nxt[1].ope     = cir_pkg::E_ONE +
                       17'((s_r[0].ea < s_r[0].eb) ? s_r[0].ea : s_r[0].eb);

    s_nxt[2]         = mu_ctx;
    s_nxt[2].mu      = mu_root;

    // positional correction
    s_nxt[3]         = c_ctx;
    s_nxt[3].cv      = cir_pkg::vec_mul(c_ctx.n, c_q[0], FRAC_BITS);

    s_nxt[4]         = s_r[3];
    s_nxt[4].da      = cir_pkg::vec_mul(s_r[3].cv, cir_pkg::im_fx(s_r[3].ima), FRAC_BITS);
    s_nxt[4].db      = cir_pkg::vec_mul(s_r[3].cv, cir_pkg::im_fx(s_r[3].imb), FRAC_BITS);

    s_nxt[5]         = s_r[4];
    if (s_r[4].act && s_r[4].pen_pos && !s_r[4].sa) begin
      s_nxt[5].pa    = cir_pkg::vec_sub(s_r[4].pa, s_r[4].da);
    end
    if (s_r[4].act && s_r[4].pen_pos && !s_r[4].sb) begin
      s_nxt[5].pb    = cir_pkg::vec_add(s_r[4].pb, s_r[4].db);
    end
    s_nxt[5].rv      = cir_pkg::vec_sub(s_r[4].vb, s_r[4].va);

    // normal impulse
    s_nxt[6]         = s_r[5];
    s_nxt[6].tdx     = cir_pkg::fx_term(s_r[5].rv.x, s_r[5].n.x, FRAC_BITS);
    s_nxt[6].tdy     = cir_pkg::fx_term(s_r[5].rv.y, s_r[5].n.y, FRAC_BITS);

    s_nxt[7]         = s_r[6];
    s_nxt[7].vn      = cir_pkg::sat_fx(s_r[6].tdx + s_r[6].tdy);
    s_nxt[7].imp     = s_r[6].act && (s_nxt[7].vn <= 0);

    s_nxt[8]         = jq_ctx;
    s_nxt[8].j       = cir_pkg::fx_mul(jq_q[0], cir_pkg::fx_t'({15'd0, jq_ctx.ope}),
                                       cir_pkg::EQ_FRAC);

    s_nxt[9]         = s_r[8];
    s_nxt[9].iv      = cir_pkg::vec_mul(s_r[8].n, s_r[8].j, FRAC_BITS);

    s_nxt[10]        = s_r[9];
    s_nxt[10].da     = cir_pkg::vec_mul(s_r[9].iv, cir_pkg::im_fx(s_r[9].ima), FRAC_BITS);
    s_nxt[10].db     = cir_pkg::vec_mul(s_r[9].iv, cir_pkg::im_fx(s_r[9].imb), FRAC_BITS);

    s_nxt[11]        = s_r[10];
    if (s_r[10].imp) begin
      s_nxt[11].va   = cir_pkg::vec_sub(s_r[10].va, s_r[10].da);
      s_nxt[11].vb   = cir_pkg::vec_add(s_r[10].vb, s_r[10].db);
    end

    // tangent of the relative velocity
    s_nxt[12]        = s_r[11];
    s_nxt[12].rv     = cir_pkg::vec_sub(s_r[11].vb, s_r[11].va);

    s_nxt[13]        = s_r[12];
    s_nxt[13].tdx    = cir_pkg::fx_term(s_r[12].rv.x, s_r[12].n.x, FRAC_BITS);
    s_nxt[13].tdy    = cir_pkg::fx_term(s_r[12].rv.y, s_r[12].n.y, FRAC_BITS);

    s_nxt[14]        = s_r[13];
    s_nxt[14].vn     = cir_pkg::sat_fx(s_r[13].tdx + s_r[13].tdy);

    s_nxt[15]        = s_r[14];
    s_nxt[15].iv     = cir_pkg::vec_mul(s_r[14].n, s_r[14].vn, FRAC_BITS);

    s_nxt[16]        = s_r[15];
    s_nxt[16].t      = cir_pkg::vec_sub(s_r[15].rv, s_r[15].iv);

    s_nxt[17]        = s_r[16];
    s_nxt[17].tsq_x  = 64'(64'(s_r[16].t.x) * 64'(s_r[16].t.x));
    s_nxt[17].tsq_y  = 64'(64'(s_r[16].t.y) * 64'(s_r[16].t.y));

    s_nxt[18]        = s_r[17];
    s_nxt[18].tsq    = s_r[17].tsq_x + s_r[17].tsq_y;

    s_nxt[19]        = len_ctx;
    s_nxt[19].len    = len_root;
    s_nxt[19].fric   = len_ctx.act && (len_root != '0);

    // friction impulse
    s_nxt[20]        = u_ctx;
    s_nxt[20].u.x    = u_q[0];
    s_nxt[20].u.y    = u_q[1];
    s_nxt[20].tdx    = cir_pkg::fx_term(u_ctx.rv.x, u_q[0], FRAC_BITS);
    s_nxt[20].tdy    = cir_pkg::fx_term(u_ctx.rv.y, u_q[1], FRAC_BITS);

    s_nxt[21]        = s_r[20];
    s_nxt[21].dtu    = cir_pkg::sat_fx(s_r[20].tdx + s_r[20].tdy);

    s_nxt[22]        = f_ctx;
    s_nxt[22].jt     = f_q[0];
    s_nxt[22].lim    = cir_pkg::fx_mul(f_q[1], cir_pkg::fx_t'({16'd0, f_ctx.mu}),
                                       cir_pkg::EQ_FRAC);

    s_nxt[23]        = s_r[22];
    if (s_r[22].jt > s_r[22].lim) begin
      s_nxt[23].jt   = s_r[22].lim;
    end else if (s_r[22].jt < -s_r[22].lim) begin
      s_nxt[23].jt   = -s_r[22].lim;
    end

    s_nxt[24]        = s_r[23];
    s_nxt[24].iv     = cir_pkg::vec_mul(s_r[23].u, s_r[23].jt, FRAC_BITS);

    s_nxt[25]        = s_r[24];
    s_nxt[25].da     = cir_pkg::vec_mul(s_r[24].iv, cir_pkg::im_fx(s_r[24].ima), FRAC_BITS);
    s_nxt[25].db     = cir_pkg::vec_mul(s_r[24].iv, cir_pkg::im_fx(s_r[24].imb), FRAC_BITS);

    s_nxt[26]        = s_r[25];
    if (s_r[25].fric) begin
      s_nxt[26].va   = cir_pkg::vec_sub(s_r[25].va, s_r[25].da);
      s_nxt[26].vb   = cir_pkg::vec_add(s_r[25].vb, s_r[25].db);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      s_r[k] <= s_nxt[k];
    end
  end

  // valid bits; stages fed by a unit take its valid
  always_comb begin
    v_nxt[0] = start && !busy_r;
    for (int k = 1; k < NSTG; k++) begin
      v_nxt[k] = v_r[k-1];
    end
    v_nxt[2]  = mu_v;
    v_nxt[3]  = c_v;
    v_nxt[8]  = jq_v;
    v_nxt[19] = len_v;
    v_nxt[20] = u_v;
    v_nxt[22] = f_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        v_r[k] <= v_nxt[k];
      end
    end
  end

  cir_sqrt #(.W(32), .SIDE_W(CTX_W)) u_mu_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v_r[1]),
    .in_val   (s_r[1].mu_sq),
    .in_side  (s_r[1]),
    .out_v    (mu_v),
    .out_root (mu_root),
    .out_side (mu_ctx)
  );

  assign c_mag[0] = cir_pkg::fx_mag(s_r[2].pen);

  cir_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SIDE_W(CTX_W)) u_corr_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v_r[2]),
    .in_neg   (1'b0),
    .in_mag   (c_mag),
    .in_den   (s_r[2].total),
    .in_side  (s_r[2]),
    .out_v    (c_v),
    .out_q    (c_q),
    .out_side (c_ctx)
  );

  // only used when vn is not positive, where |vn| equals -vn
  assign jq_mag[0] = cir_pkg::fx_mag(s_r[7].vn);

  cir_div #(.FRAC_BITS(FRAC_BITS), .LANES(1), .SIDE_W(CTX_W)) u_norm_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v_r[7]),
    .in_neg   (1'b0),
    .in_mag   (jq_mag),
    .in_den   (s_r[7].total),
    .in_side  (s_r[7]),
    .out_v    (jq_v),
    .out_q    (jq_q),
    .out_side (jq_ctx)
  );

  cir_sqrt #(.W(64), .SIDE_W(CTX_W)) u_len_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v_r[18]),
    .in_val   (s_r[18].tsq),
    .in_side  (s_r[18]),
    .out_v    (len_v),
    .out_root (len_root),
    .out_side (len_ctx)
  );

  assign u_mag[0] = cir_pkg::fx_mag(s_r[19].t.x);
  assign u_mag[1] = cir_pkg::fx_mag(s_r[19].t.y);
  assign u_neg    = {s_r[19].t.y < 0, s_r[19].t.x < 0};

  cir_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SIDE_W(CTX_W)) u_tan_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v_r[19]),
    .in_neg   (u_neg),
    .in_mag   (u_mag),
    .in_den   (s_r[19].len),
    .in_side  (s_r[19]),
    .out_v    (u_v),
    .out_q    (u_q),
    .out_side (u_ctx)
  );

  // lane 0 divides -(rv . u), lane 1 the friction limit |vn|
  assign f_mag[0] = cir_pkg::fx_mag(s_r[21].dtu);
  assign f_mag[1] = cir_pkg::fx_mag(s_r[21].vn);
  assign f_neg    = {1'b0, s_r[21].dtu > 0};

  cir_div #(.FRAC_BITS(FRAC_BITS), .LANES(2), .SIDE_W(CTX_W)) u_fric_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v_r[21]),
    .in_neg   (f_neg),
    .in_mag   (f_mag),
    .in_den   (s_r[21].total),
    .in_side  (s_r[21]),
    .out_v    (f_v),
    .out_q    (f_q),
    .out_side (f_ctx)
  );

  assign out_strobe              = v_r[NSTG-1];
  assign out_data.new_a_position = s_r[NSTG-1].pa;
  assign out_data.new_a_velocity = s_r[NSTG-1].va;
  assign out_data.new_b_position = s_r[NSTG-1].pb;
  assign out_data.new_b_velocity = s_r[NSTG-1].vb;

  // clamped friction impulse stays within the limit
  a_fric_clamp : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[23] |-> (s_r[23].jt <= s_r[23].lim) && (s_r[23].jt >= -s_r[23].lim))
    else $error("friction impulse exceeds its limit");

  // a static body keeps its position through the correction stage
  a_static_a : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] && s_r[5].sa |-> s_r[5].pa == $past(s_r[4].pa))
    else $error("static body A moved");

  a_static_b : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] && s_r[5].sb |-> s_r[5].pb == $past(s_r[4].pb))
    else $error("static body B moved");

  // no normal impulse while separating
  a_no_imp : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[11] && !s_r[11].imp |-> s_r[11].va == $past(s_r[10].va))
    else $error("velocity changed without a normal impulse");

  // friction only for contacts with mass
  a_fric_act : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[19] && s_r[19].fric |-> s_r[19].act)
    else $error("friction on a massless contact");

endmodule

`default_nettype wire

// File: tb/contact_impulse_resolver_2d_tb.sv
`timescale 1ns / 1ps

module contact_impulse_resolver_2d_tb;

  localparam int FB = 16;
  localparam int LATENCY = 205;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  cir_pkg::in_t in_data;
  logic out_strobe;
  cir_pkg::out_t out_data;

  contact_impulse_resolver_2d #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data)
  );

  cir_pkg::out_t resolved_q[$];
  int errors = 0;
  longint cycles = 0;

  logic plan_fixed_now = 1'b0;
  cir_pkg::out_t plan_want_now = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint lo_s(logic [63:0] w);
    return longint'($signed(w[31:0]));
  endfunction

  function automatic longint hi_s(logic [63:0] w);
    return longint'($signed(w[63:32]));
  endfunction

  // exact product then floor shift; 32x32 fits in 64 bits
  function automatic longint fl_prod(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip32(fl_prod(a, b));
  endfunction

  function automatic longint qdiv(longint num, longint den);
    return clip32((num * (64'sd1 <<< FB)) / den);
  endfunction

  function automatic longint qdot(longint ax, longint ay, longint bx, longint by);
    return clip32(fl_prod(ax, bx) + fl_prod(ay, by));
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= r + bit_v) begin
        v -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] join_xy(longint x, longint y);
    return {y[31:0], x[31:0]};
  endfunction

  function automatic cir_pkg::out_t resolve_contact(cir_pkg::in_t c);
    cir_pkg::out_t r;
    longint pax, pay, vax, vay, pbx, pby, vbx, vby, nx, ny, ima, imb, tot, pen;
    longint corr, cx, cy, rx, ry, vn, ea, eb, ope, q, jj, ix, iy;
    longint tx, ty, len, fa, fb, mu, ux, uy, jt, lim;
    pax = lo_s(c.a_position); pay = hi_s(c.a_position);
    vax = lo_s(c.a_velocity); vay = hi_s(c.a_velocity);
    pbx = lo_s(c.b_position); pby = hi_s(c.b_position);
    vbx = lo_s(c.b_velocity); vby = hi_s(c.b_velocity);
    nx = lo_s(c.contact_normal); ny = hi_s(c.contact_normal);
    ima = longint'(c.a_inv_mass); imb = longint'(c.b_inv_mass);
    tot = ima + imb;
    pen = longint'(c.penetration);
    if (tot > 0) begin
      if (pen > 0) begin
        corr = qdiv(pen, tot);
        cx = qmul(nx, corr); cy = qmul(ny, corr);
        if (!c.a_static) begin
          pax = clip32(pax - qmul(cx, ima));
          pay = clip32(pay - qmul(cy, ima));
        end
        if (!c.b_static) begin
          pbx = clip32(pbx + qmul(cx, imb));
          pby = clip32(pby + qmul(cy, imb));
        end
      end
      rx = clip32(vbx - vax); ry = clip32(vby - vay);
      vn = qdot(rx, ry, nx, ny);
      if (vn <= 0) begin
        ea = longint'(c.a_material[15:0]); eb = longint'(c.b_material[15:0]);
        ope = 65536 + ((ea < eb) ? ea : eb);
        q = qdiv(-vn, tot);
        jj = clip32((q * ope) >>> 16);
        ix = qmul(nx, jj); iy = qmul(ny, jj);
        vax = clip32(vax - qmul(ix, ima)); vay = clip32(vay - qmul(iy, ima));
        vbx = clip32(vbx + qmul(ix, imb)); vby = clip32(vby + qmul(iy, imb));
      end
      rx = clip32(vbx - vax); ry = clip32(vby - vay);
      vn = qdot(rx, ry, nx, ny);
      tx = clip32(rx - qmul(nx, vn));
      ty = clip32(ry - qmul(ny, vn));
      len = longint'(floor_root(longint'(tx * tx) + longint'(ty * ty)));
      if (len > 0) begin
        fa = longint'(c.a_material[31:16]); fb = longint'(c.b_material[31:16]);
        mu = longint'(floor_root(fa * fb));
        ux = qdiv(tx, len); uy = qdiv(ty, len);
        jt = qdiv(-qdot(rx, ry, ux, uy), tot);
        lim = (qdiv((vn < 0) ? -vn : vn, tot) * mu) >>> 16;
        if (jt > lim) jt = lim;
        if (jt < -lim) jt = -lim;
        ix = qmul(ux, jt); iy = qmul(uy, jt);
        vax = clip32(vax - qmul(ix, ima)); vay = clip32(vay - qmul(iy, ima));
        vbx = clip32(vbx + qmul(ix, imb)); vby = clip32(vby + qmul(iy, imb));
      end
    end
    r.new_a_position = join_xy(pax, pay);
    r.new_a_velocity = join_xy(vax, vay);
    r.new_b_position = join_xy(pbx, pby);
    r.new_b_velocity = join_xy(vbx, vby);
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // small Q16.16 value in +-range units
  function automatic logic [31:0] rnd_fx(int unsigned units);
    int v;
    v = int'($urandom_range(2 * units * 65536)) - int'(units * 65536);
    return v;
  endfunction

  function automatic logic [63:0] rnd_vec(int unsigned units);
    return {rnd_fx(units), rnd_fx(units)};
  endfunction

  // roughly unit normal from a few fixed directions, random sign
  function automatic logic [63:0] rnd_normal();
    logic [31:0] a, b;
    int s;
    s = $urandom_range(3);
    case (s)
      0: begin a = 32'h0001_0000; b = 32'h0; end
      1: begin a = 32'h0; b = 32'h0001_0000; end
      2: begin a = 32'h0000_b505; b = 32'h0000_b505; end
      default: begin a = 32'h0000_93cd; b = 32'h0000_ddb4; end
    endcase
    if ($urandom_range(1)) a = -a;
    if ($urandom_range(1)) b = -b;
    return {b, a};
  endfunction

  function automatic cir_pkg::in_t rnd_contact();
    cir_pkg::in_t c;
    int mode;
    mode = $urandom_range(9);
    if (mode == 0) begin
      // raw noise over every bit
      c = {rnd64(), rnd64(), $urandom(), $urandom(), rnd64(), rnd64(),
           $urandom(), $urandom(), rnd64(), rnd64(), $urandom()};
    end else begin
      c.a_position = rnd_vec(1000);
      c.b_position = rnd_vec(1000);
      c.a_velocity = rnd_vec(50);
      c.b_velocity = rnd_vec(50);
      c.a_inv_mass = (mode == 1) ? 31'd0 : 31'($urandom_range(4 * 65536));
      c.b_inv_mass = (mode == 2) ? 31'd0 : 31'($urandom_range(4 * 65536));
      c.a_material = $urandom();
      c.b_material = $urandom();
      c.a_static = ($urandom_range(4) == 0);
      c.b_static = ($urandom_range(4) == 0);
      c.contact_normal = (mode == 3) ? rnd64() : rnd_normal();
      c.penetration = (mode == 4) ? $urandom() : rnd_fx(2);
    end
    return c;
  endfunction

  // ---------------- directed table ----------------
  typedef struct {
    cir_pkg::in_t  stim;
    logic          fixed;   // expected typed in below
    cir_pkg::out_t want;
  } case_row_t;

  case_row_t plan[$];

  function automatic cir_pkg::in_t base_contact();
    cir_pkg::in_t c;
    c.a_position = {32'sh0001_0000, 32'sh0002_0000};
    c.a_velocity = {32'sh0, 32'sh0003_0000};
    c.a_inv_mass = 31'h1_0000;
    c.a_material = 32'h8000_4000;
    c.a_static = 1'b0;
    c.b_position = {32'sh0001_0000, 32'sh0003_0000};
    c.b_velocity = {32'sh0, -32'sh0002_0000};
    c.b_inv_mass = 31'h1_0000;
    c.b_material = 32'h4000_8000;
    c.b_static = 1'b0;
    c.contact_normal = {32'sh0, 32'sh0001_0000};
    c.penetration = 32'sh0000_4000;
    return c;
  endfunction

  task automatic add_row(cir_pkg::in_t c, logic fixed, cir_pkg::out_t want);
    case_row_t r;
    r.stim = c;
    r.fixed = fixed;
    r.want = want;
    plan.push_back(r);
  endtask

  task automatic build_plan();
    cir_pkg::in_t c;
    cir_pkg::out_t pass_w;
    c = base_contact();
    add_row(c, 1'b0, '0);
    // both masses infinite: everything passes through
    c.a_inv_mass = '0; c.b_inv_mass = '0;
    pass_w = {c.a_position, c.a_velocity, c.b_position, c.b_velocity};
    add_row(c, 1'b1, pass_w);
    c = '1; c.a_inv_mass = '0; c.b_inv_mass = '0;
    pass_w = {c.a_position, c.a_velocity, c.b_position, c.b_velocity};
    add_row(c, 1'b1, pass_w);
    c = '0;
    add_row(c, 1'b1, '0);
    // non-positive and maximum penetration
    c = base_contact(); c.penetration = 0; add_row(c, 1'b0, '0);
    c.penetration = 32'sh8000_0000; add_row(c, 1'b0, '0);
    c.penetration = 32'sh7fff_ffff; add_row(c, 1'b0, '0);
    // separating bodies
    c = base_contact(); c.a_velocity = {32'sh0, -32'sh0003_0000};
    c.b_velocity = {32'sh0, 32'sh0003_0000}; add_row(c, 1'b0, '0);
    // zero tangent: head-on along normal
    c = base_contact(); add_row(c, 1'b0, '0);
    // tangential motion with friction
    c.b_velocity = {32'sh0005_0000, -32'sh0002_0000}; add_row(c, 1'b0, '0);
    // static bodies
    c.a_static = 1'b1; add_row(c, 1'b0, '0);
    c.a_static = 1'b0; c.b_static = 1'b1; add_row(c, 1'b0, '0);
    c.a_static = 1'b1; add_row(c, 1'b0, '0);
    // one side infinite mass, then one side with the largest inverse mass
    c = base_contact(); c.a_inv_mass = '0; add_row(c, 1'b0, '0);
    c = base_contact(); c.b_inv_mass = '1; add_row(c, 1'b0, '0);
    // non-unit normal and extreme values
    c = base_contact(); c.contact_normal = {32'sh0003_0000, 32'sh7fff_ffff};
    add_row(c, 1'b0, '0);
    c = base_contact(); c.a_velocity = {32'sh8000_0000, 32'sh8000_0000};
    c.b_velocity = {32'sh7fff_ffff, 32'sh7fff_ffff}; add_row(c, 1'b0, '0);
    c.a_material = '1; c.b_material = '1; add_row(c, 1'b0, '0);
    c.a_material = '0; c.b_material = '0; add_row(c, 1'b0, '0);
    c = '1; add_row(c, 1'b0, '0);
    c = '1; c.penetration = 32'sh7fff_ffff; c.a_static = 0; add_row(c, 1'b0, '0);
    c = base_contact(); c.a_inv_mass = 31'd1; c.b_inv_mass = '0;
    c.penetration = 32'sh7fff_ffff; add_row(c, 1'b0, '0);
  endtask

  // ---------------- driver ----------------
  // leaves start high after the transfer; the next call may drop it, else the caller does
  task automatic send_contact(cir_pkg::in_t c, logic hold_idle);
    if (!hold_idle) begin
      while ($urandom_range(99) < 30) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    in_data <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // prediction is made at the transfer edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      if (plan_fixed_now) resolved_q.push_back(plan_want_now);
      else resolved_q.push_back(resolve_contact(in_data));
    end
  end

  // ---------------- checker ----------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_strobe) begin
      if (resolved_q.size() == 0) begin
        $display("%0t unexpected result: %h", $time, out_data);
        errors++;
      end else begin
        cir_pkg::out_t w;
        w = resolved_q.pop_front();
        if (w.new_a_position !== out_data.new_a_position) begin
          $display("%0t new_a_position expected %h actual %h", $time,
                   w.new_a_position, out_data.new_a_position);
          errors++;
        end
        if (w.new_a_velocity !== out_data.new_a_velocity) begin
          $display("%0t new_a_velocity expected %h actual %h", $time,
                   w.new_a_velocity, out_data.new_a_velocity);
          errors++;
        end
        if (w.new_b_position !== out_data.new_b_position) begin
          $display("%0t new_b_position expected %h actual %h", $time,
                   w.new_b_position, out_data.new_b_position);
          errors++;
        end
        if (w.new_b_velocity !== out_data.new_b_velocity) begin
          $display("%0t new_b_velocity expected %h actual %h", $time,
                   w.new_b_velocity, out_data.new_b_velocity);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("contact_impulse_resolver_2d_tb: errors");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    int drain;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    build_plan();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      plan_fixed_now <= plan[i].fixed;
      plan_want_now <= plan[i].want;
      send_contact(plan[i].stim, 1'b0);
    end
    plan_fixed_now <= 1'b0;
    start <= 1'b0;

    // hold the sender until every result has drained
    while (resolved_q.size() != 0) @(negedge clk);

    for (int k = 0; k < 1250; k++) begin
      send_contact(rnd_contact(), (k >= 400 && k < 700));
    end
    start <= 1'b0;

    drain = 0;
    while (resolved_q.size() != 0 && drain < 4 * LATENCY) begin
      @(negedge clk);
      drain++;
    end
    repeat (LATENCY) @(negedge clk);
    if (errors == 0 && resolved_q.size() == 0) begin
      $display("contact_impulse_resolver_2d_tb: clean");
    end else begin
      if (resolved_q.size() != 0)
        $display("%0t %0d results never arrived", $time, resolved_q.size());
      $display("contact_impulse_resolver_2d_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/cir_pkg.sv
sv/cir_div.sv
sv/cir_sqrt.sv
sv/contact_impulse_resolver_2d.sv
tb/contact_impulse_resolver_2d_tb.sv
